[rtl/core/pgbm_pkg.sv]
// shared types and constants of the point grid binning block
package pgbm_pkg;

  localparam int IdxW   = 20;
  localparam int SumW   = 64;
  localparam int CountW = 32;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_CELL_SIZE    = 3'd2,
    CFG_GRID_COLUMNS = 3'd3,
    CFG_GRID_ROWS    = 3'd4,
    CFG_VALUE_MODE   = 3'd5,
    CFG_CLASS_FILTER = 3'd6,
    CFG_CLASS_MASK   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_Z         = 2'd0,
    MODE_INTENSITY = 2'd1,
    MODE_COUNT     = 2'd2,
    MODE_SPARE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_REJECT    = 2'd0,
    OP_ADD       = 2'd1,
    OP_READ      = 2'd2,
    OP_READ_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE, F_CHECK, F_DIV, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_RD_WAIT, B_DIV, B_OUT
  } back_state_t;

  typedef struct packed {
    logic               command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        point_intensity;
    logic [4:0]         class_code;
    logic [5:0]         read_row;
    logic [5:0]         read_column;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] cell_value;
    logic               cell_empty;
    logic [31:0]        cell_count;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [30:0]        cell_size;
    logic [6:0]         grid_columns;
    logic [6:0]         grid_rows;
    mode_t              value_mode;
    logic               class_filter_on;
    logic [31:0]        class_mask;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [IdxW-1:0]    idx;
    logic signed [31:0] addend;
  } q_entry_t;

  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
  } cell_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[rtl/core/pgbm_ifs.sv]
// valid/ready channel interfaces for point items and cell results
interface pgbm_in_if;
  import pgbm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pgbm_out_if;
  import pgbm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/pgbm_ram.sv]
// generic single write port ram with registered read
module pgbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[rtl/core/pgbm_div.sv]
// iterative restoring unsigned divider, one quotient bit per cycle
module pgbm_div #(
  parameter int NW = 32,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, q_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt = {q_r[NW-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt  = DW'(rem_sh - {1'b0, dvs_r});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = rem_sh[DW-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

[rtl/core/pgbm_fifo.sv]
// two entry queue between the classifying front and the cell update back
module pgbm_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  pgbm_pkg::q_entry_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pgbm_pkg::q_entry_t pop_data
);
  import pgbm_pkg::*;

  q_entry_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

[rtl/core/pgbm_front.sv]
// front part: takes items, filters and finds the cell index
module pgbm_front #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pgbm_pkg::cfg_t     cfg,
  input  logic               hold,
  pgbm_in_if.sink            in_ch,
  output logic               q_valid,
  input  logic               q_ready,
  output pgbm_pkg::q_entry_t q_data
);
  import pgbm_pkg::*;

  front_state_t       state_r, state_nxt;
  in_item_t           item_r;
  q_entry_t           ent_r, ent_nxt;
  logic signed [32:0] dx, dy;
  logic [30:0]        size_eff;
  logic               div_start, x_done, y_done;
  logic [31:0]        qx, qy;
  logic               filt_fail, in_grid;

  assign dx       = 33'(item_r.point_x) - 33'(cfg.origin_x);
  assign dy       = 33'(item_r.point_y) - 33'(cfg.origin_y);
  assign size_eff = (cfg.cell_size == '0) ? 31'd1 : cfg.cell_size;
  assign filt_fail = cfg.class_filter_on && !cfg.class_mask[item_r.class_code];
  assign in_grid  = (qx < 32'(cfg.grid_columns)) && (qx < 32'(MAX_COLUMNS)) &&
                    (qy < 32'(cfg.grid_rows)) && (qy < 32'(MAX_ROWS));

  pgbm_div #(.NW(32), .DW(31)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dx[31:0]),
    .divisor(size_eff), .done(x_done), .quotient(qx)
  );

  pgbm_div #(.NW(32), .DW(31)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dy[31:0]),
    .divisor(size_eff), .done(y_done), .quotient(qy)
  );

  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    div_start   = 1'b0;
    in_ch.ready = (state_r == F_IDLE) && !hold;
    q_valid     = (state_r == F_PUSH);
    case (state_r)
      F_IDLE: begin
        if (in_ch.valid && !hold) begin
          state_nxt = F_CHECK;
        end
      end
      F_CHECK: begin
        ent_nxt.addend = 32'sd0;
        case (cfg.value_mode)
          MODE_INTENSITY: ent_nxt.addend = signed'(32'(item_r.point_intensity));
          MODE_COUNT:     ent_nxt.addend = 32'sd0;
          default:        ent_nxt.addend = item_r.point_z;
        endcase
        if (item_r.command == CMD_READ) begin
          ent_nxt.idx = IdxW'(item_r.read_row) * IdxW'(MAX_COLUMNS) +
                        IdxW'(item_r.read_column);
          ent_nxt.op  = ((32'(item_r.read_row) >= 32'(MAX_ROWS)) ||
                         (32'(item_r.read_column) >= 32'(MAX_COLUMNS))) ?
                        OP_READ_NONE : OP_READ;
          state_nxt   = F_PUSH;
        end else if (filt_fail || dx[32] || dy[32]) begin
          ent_nxt.op = OP_REJECT;
          state_nxt  = F_PUSH;
        end else begin
          div_start = 1'b1;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        if (x_done) begin
          ent_nxt.op  = in_grid ? OP_ADD : OP_REJECT;
          ent_nxt.idx = IdxW'(qy[IdxW-1:0]) * IdxW'(MAX_COLUMNS) + IdxW'(qx[IdxW-1:0]);
          state_nxt   = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ent_r <= ent_nxt;
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.payload;
    end
  end

  assign q_data = ent_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == F_CHECK)
    else $error("item taken outside idle");
  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    x_done == y_done)
    else $error("coordinate dividers out of step");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    x_done |-> state_r == F_DIV)
    else $error("divider finished outside divide state");
endmodule

[rtl/core/pgbm_back.sv]
// back part: clears the store, updates or reads and clears cells, forms results
module pgbm_back #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pgbm_pkg::cfg_t         cfg,
  output pgbm_pkg::back_status_t status,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  pgbm_pkg::q_entry_t     q_data,
  pgbm_out_if.source             out_ch
);
  import pgbm_pkg::*;

  localparam int Cells  = MAX_ROWS * MAX_COLUMNS;
  localparam int CellAw = (Cells > 1) ? $clog2(Cells) : 1;

  back_state_t       state_r, state_nxt;
  q_entry_t          ent_r, ent_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_data_r;
  logic              out_valid_r;
  logic              neg_r, neg_nxt;
  logic [CellAw-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              ram_we, ram_re;
  logic [CellAw-1:0] ram_waddr, ram_raddr;
  cell_t             ram_wdata, ram_rdata;
  logic              div_start, div_done;
  logic [SumW-1:0]   sum_abs, div_q;
  logic [31:0]       mean_mag;
  logic              slot_free;

  pgbm_ram #(.WIDTH($bits(cell_t)), .DEPTH(Cells)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  pgbm_div #(.NW(SumW), .DW(CountW)) u_div_mean (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_abs),
    .divisor(ram_rdata.count), .done(div_done), .quotient(div_q)
  );

  assign sum_abs   = ram_rdata.sum[SumW-1] ? (~ram_rdata.sum + 1'b1) : ram_rdata.sum;
  assign mean_mag  = div_q[31:0];
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    res_nxt     = res_r;
    neg_nxt     = neg_r;
    clr_cnt_nxt = clr_cnt_r;
    ram_we      = 1'b0;
    ram_waddr   = ent_r.idx[CellAw-1:0];
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = q_data.idx[CellAw-1:0];
    div_start   = 1'b0;
    q_ready     = 1'b0;
    case (state_r)
      B_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CellAw'(Cells - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          ent_nxt = q_data;
          res_nxt = '{accepted: 1'b0, cell_value: 32'sd0, cell_empty: 1'b0,
                      cell_count: 32'd0};
          case (q_data.op)
            OP_REJECT: state_nxt = B_OUT;
            OP_READ_NONE: begin
              res_nxt.accepted   = 1'b1;
              res_nxt.cell_empty = 1'b1;
              state_nxt          = B_OUT;
            end
            default: begin
              ram_re    = 1'b1;
              state_nxt = B_RD_WAIT;
            end
          endcase
        end
      end
      B_RD_WAIT: begin
        res_nxt.accepted = 1'b1;
        if (ent_r.op == OP_ADD) begin
          if (ram_rdata.count != '1) begin
            ram_we          = 1'b1;
            ram_wdata.count = ram_rdata.count + 1'b1;
            ram_wdata.sum   = ram_rdata.sum + SumW'(ent_r.addend);
            res_nxt.cell_count = ram_rdata.count + 1'b1;
          end else begin
            res_nxt.cell_count = ram_rdata.count;
          end
          state_nxt = B_OUT;
        end else begin
          // read clears the cell whatever it held
          ram_we             = 1'b1;
          res_nxt.cell_count = ram_rdata.count;
          if (ram_rdata.count == '0) begin
            res_nxt.cell_empty = 1'b1;
            state_nxt          = B_OUT;
          end else if (cfg.value_mode == MODE_COUNT) begin
            res_nxt.cell_value = ram_rdata.count[31] ? 32'sh7FFFFFFF :
                                 signed'(ram_rdata.count);
            state_nxt = B_OUT;
          end else begin
            neg_nxt   = ram_rdata.sum[SumW-1];
            div_start = 1'b1;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        if (div_done) begin
          res_nxt.cell_value = neg_r ? signed'(~mean_mag + 1'b1) : signed'(mean_mag);
          state_nxt          = B_OUT;
        end
      end
      B_OUT: begin
        if (slot_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (state_r == B_OUT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    ent_r <= ent_nxt;
    res_r <= res_nxt;
    neg_r <= neg_nxt;
    if (state_r == B_OUT && slot_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.payload  = out_data_r;
  assign status.clearing = (state_r == B_CLEAR);

  a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLEAR |-> !q_ready)
    else $error("queue popped during clearing pass");
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == B_CLEAR || state_r == B_RD_WAIT))
    else $error("cell store written outside update");
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == B_DIV)
    else $error("mean divider finished outside divide state");
endmodule

[rtl/core/point_grid_binning_mean.sv]
// top level of the point grid binning block with per-cell mean
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      command, point x/y/z, intensity, class, read row/column
//  out_ch   out  valid/ready      accepted, cell_value, cell_empty, cell_count
//  cfg_*    in   cfg_we only      cfg_index selects register, cfg_wdata 32 bit
//
//  add transaction: the front runs the 32 step coordinate dividers unless the point is filtered or below the origin
//  read transaction: the back runs the 64 step mean divider unless the cell is empty or the mode is count
//  after reset a clearing pass writes every cell, no items taken
//  a two entry queue lets the front classify while the back updates or waits on out_ch
module point_grid_binning_mean #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pgbm_in_if.sink     in_ch,
  pgbm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import pgbm_pkg::*;

  cfg_t         cfg_r;
  back_status_t bstat;
  logic         f_valid, f_ready, b_valid, b_ready;
  q_entry_t     f_data, b_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x        <= 32'sd0;
      cfg_r.origin_y        <= 32'sd0;
      cfg_r.cell_size       <= 31'd1;
      cfg_r.grid_columns    <= 7'd64;
      cfg_r.grid_rows       <= 7'd64;
      cfg_r.value_mode      <= MODE_Z;
      cfg_r.class_filter_on <= 1'b0;
      cfg_r.class_mask      <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:     cfg_r.origin_x        <= signed'(cfg_wdata);
        CFG_ORIGIN_Y:     cfg_r.origin_y        <= signed'(cfg_wdata);
        CFG_CELL_SIZE:    cfg_r.cell_size       <= cfg_wdata[30:0];
        CFG_GRID_COLUMNS: cfg_r.grid_columns    <= cfg_wdata[6:0];
        CFG_GRID_ROWS:    cfg_r.grid_rows       <= cfg_wdata[6:0];
        CFG_VALUE_MODE:   cfg_r.value_mode      <= mode_t'(cfg_wdata[1:0]);
        CFG_CLASS_FILTER: cfg_r.class_filter_on <= cfg_wdata[0];
        CFG_CLASS_MASK:   cfg_r.class_mask      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pgbm_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .hold(bstat.clearing),
    .in_ch(in_ch), .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  pgbm_fifo u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
  );

  pgbm_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .status(bstat),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data), .out_ch(out_ch)
  );
endmodule
